// ----- rtl/idav_pkg.sv -----
// ----------------------------------------------------------------------------
// idav_pkg
// Types and constants shared by the indirect draw argument validator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package idav_pkg;

  // Request kinds, carried on the input tuser.
  typedef enum logic [2:0] {
    REQ_CHK_DRAW  = 3'd0,
    REQ_CHK_IDX   = 3'd1,
    REQ_CHK_DISP  = 3'd2,
    REQ_SAN_DRAW  = 3'd3,
    REQ_SAN_IDX   = 3'd4,
    REQ_SAN_DISP  = 3'd5,
    REQ_CLR_ERR   = 3'd6,
    REQ_RST_STATS = 3'd7
  } req_e;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 48;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_VTX   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_IDX   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_INST  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_AXIS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TOTAL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WARN_ZERO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LOG   = 3'd6;

  // Reset values of the configuration registers.
  localparam logic [31:0] RST_MAX_VTX   = 32'd16777216;
  localparam logic [31:0] RST_MAX_IDX   = 32'd16777216;
  localparam logic [31:0] RST_MAX_INST  = 32'd65536;
  localparam logic [31:0] RST_MAX_AXIS  = 32'd65535;
  localparam logic [47:0] RST_MAX_TOTAL = 48'd4194304;
  localparam logic [15:0] RST_MAX_LOG   = 16'd1024;

  // Issue mask bit positions.
  localparam int unsigned ISSUE_W       = 11;
  localparam int unsigned ISS_ZERO_VTX  = 0;
  localparam int unsigned ISS_ZERO_IDX  = 1;
  localparam int unsigned ISS_ZERO_INST = 2;
  localparam int unsigned ISS_ZERO_GRP  = 3;
  localparam int unsigned ISS_EXC_VTX   = 4;
  localparam int unsigned ISS_EXC_IDX   = 5;
  localparam int unsigned ISS_EXC_INST  = 6;
  localparam int unsigned ISS_EXC_GRP   = 7;
  localparam int unsigned ISS_OOB_VTX   = 8;
  localparam int unsigned ISS_OOB_IDX   = 9;
  localparam int unsigned ISS_NEG_OFS   = 10;

  // A buffer size of all ones disables the bounds check.
  localparam logic [31:0] ALL_ONES32 = 32'hFFFF_FFFF;

  localparam int unsigned IN_TDATA_W  = 192;
  localparam int unsigned IN_TUSER_W  = 3;
  localparam int unsigned OUT_TDATA_W = 288;

  localparam int unsigned Q_DEPTH = 2;

  typedef struct packed {
    logic [31:0] max_vtx;
    logic [31:0] max_idx;
    logic [31:0] max_inst;
    logic [31:0] max_axis;
    logic [47:0] max_total;
    logic        warn_zero;
    logic [15:0] max_log;
  } cfg_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    req_e               req;
    logic [ISSUE_W-1:0] mask;
    logic [1:0]         zero_n;
    logic [1:0]         excess_n;
    logic               bounds_n;
    logic [2:0]         issue_n;
    logic [1:0]         clamp_n;
    logic               need_prod;
    logic [63:0]        xy;
    logic [31:0]        out_main;
    logic [31:0]        out_iy;
    logic [31:0]        out_z;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

  typedef struct packed {
    logic pop;
    logic commit;
  } bk_stat_t;

  typedef enum logic [2:0] {
    BK_IDLE   = 3'd0,
    BK_MUL_LO = 3'd1,
    BK_MUL_HI = 3'd2,
    BK_CHECK  = 3'd3,
    BK_COMMIT = 3'd4
  } bk_state_e;

endpackage

`default_nettype wire

// ----- rtl/idav_cfg.sv -----
// ----------------------------------------------------------------------------
// idav_cfg
// Configuration registers of the validator, written through a plain port.
// ----------------------------------------------------------------------------
`default_nettype none

module idav_cfg (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [idav_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [idav_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output idav_pkg::cfg_t                       cfg_o
);

  idav_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        idav_pkg::CFG_MAX_VTX:   cfg_d.max_vtx   = cfg_data_i[31:0];
        idav_pkg::CFG_MAX_IDX:   cfg_d.max_idx   = cfg_data_i[31:0];
        idav_pkg::CFG_MAX_INST:  cfg_d.max_inst  = cfg_data_i[31:0];
        idav_pkg::CFG_MAX_AXIS:  cfg_d.max_axis  = cfg_data_i[31:0];
        idav_pkg::CFG_MAX_TOTAL: cfg_d.max_total = cfg_data_i[47:0];
        idav_pkg::CFG_WARN_ZERO: cfg_d.warn_zero = cfg_data_i[0];
        idav_pkg::CFG_MAX_LOG:   cfg_d.max_log   = cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_vtx   <= idav_pkg::RST_MAX_VTX;
      cfg_q.max_idx   <= idav_pkg::RST_MAX_IDX;
      cfg_q.max_inst  <= idav_pkg::RST_MAX_INST;
      cfg_q.max_axis  <= idav_pkg::RST_MAX_AXIS;
      cfg_q.max_total <= idav_pkg::RST_MAX_TOTAL;
      cfg_q.warn_zero <= 1'b1;
      cfg_q.max_log   <= idav_pkg::RST_MAX_LOG;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- rtl/idav_front.sv -----
// ----------------------------------------------------------------------------
// idav_front
// Accepts request words and classifies them: limit, zero and bounds checks,
// sanitize clamping, and the first partial product X*Y of a dispatch.
// ----------------------------------------------------------------------------
`default_nettype none

module idav_front (
  input  wire logic                             s_axis_tvalid,
  output      logic                             s_axis_tready,
  input  wire logic [idav_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  wire logic [idav_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
  input  wire idav_pkg::cfg_t                   cfg_i,
  input  wire idav_pkg::q_stat_t                q_stat_i,
  output      logic                             q_wr_o,
  output idav_pkg::cmd_t                        cmd_o
);

  logic [31:0] a, b, z, first, voff, size, lim;
  logic        idx, z_a, z_b, e_a, e_b, oob, neg, zd, ed, c_a, c_b;
  logic [32:0] end_sum;
  idav_pkg::req_e req;

  assign a     = s_axis_tdata[31:0];
  assign b     = s_axis_tdata[63:32];
  assign z     = s_axis_tdata[95:64];
  assign first = s_axis_tdata[127:96];
  assign voff  = s_axis_tdata[159:128];
  assign size  = s_axis_tdata[191:160];
  assign req   = idav_pkg::req_e'(s_axis_tuser);

  assign s_axis_tready = !q_stat_i.full;
  assign q_wr_o        = s_axis_tvalid && !q_stat_i.full;

  always_comb begin
    idx     = (req == idav_pkg::REQ_CHK_IDX) || (req == idav_pkg::REQ_SAN_IDX);
    lim     = idx ? cfg_i.max_idx : cfg_i.max_vtx;
    end_sum = {1'b0, first} + {1'b0, a};

    z_a = (a == '0) && cfg_i.warn_zero;
    z_b = (b == '0) && cfg_i.warn_zero;
    e_a = a > lim;
    e_b = b > cfg_i.max_inst;
    oob = (size != idav_pkg::ALL_ONES32) && (end_sum > {1'b0, size});
    neg = idx && voff[31];
    zd  = ((a == '0) || (b == '0) || (z == '0)) && cfg_i.warn_zero;
    ed  = (a > cfg_i.max_axis) || (b > cfg_i.max_axis) || (z > cfg_i.max_axis);
    c_a = a > lim;
    c_b = b > cfg_i.max_inst;

    cmd_o           = '0;
    cmd_o.req       = req;
    cmd_o.out_main  = a;
    cmd_o.out_iy    = b;
    cmd_o.out_z     = z;
    cmd_o.xy        = {32'b0, a} * {32'b0, b};

    case (req)
      idav_pkg::REQ_CHK_DRAW, idav_pkg::REQ_CHK_IDX: begin
        cmd_o.mask[idav_pkg::ISS_ZERO_VTX] = z_a && !idx;
        cmd_o.mask[idav_pkg::ISS_ZERO_IDX] = z_a && idx;
        cmd_o.mask[idav_pkg::ISS_ZERO_INST] = z_b;
        cmd_o.mask[idav_pkg::ISS_EXC_VTX] = e_a && !idx;
        cmd_o.mask[idav_pkg::ISS_EXC_IDX] = e_a && idx;
        cmd_o.mask[idav_pkg::ISS_EXC_INST] = e_b;
        cmd_o.mask[idav_pkg::ISS_OOB_VTX] = oob && !idx;
        cmd_o.mask[idav_pkg::ISS_OOB_IDX] = oob && idx;
        cmd_o.mask[idav_pkg::ISS_NEG_OFS] = neg;
        cmd_o.zero_n   = 2'(z_a) + 2'(z_b);
        cmd_o.excess_n = 2'(e_a) + 2'(e_b);
        cmd_o.bounds_n = oob;
        cmd_o.issue_n  = 3'(z_a) + 3'(z_b) + 3'(e_a) + 3'(e_b) + 3'(oob) + 3'(neg);
      end
      idav_pkg::REQ_CHK_DISP: begin
        cmd_o.mask[idav_pkg::ISS_ZERO_GRP] = zd;
        cmd_o.mask[idav_pkg::ISS_EXC_GRP]  = ed;
        cmd_o.zero_n    = 2'(zd);
        cmd_o.excess_n  = 2'(ed);
        cmd_o.issue_n   = 3'(zd) + 3'(ed);
        cmd_o.need_prod = 1'b1;
      end
      idav_pkg::REQ_SAN_DRAW, idav_pkg::REQ_SAN_IDX: begin
        cmd_o.out_main = c_a ? lim : a;
        cmd_o.out_iy   = c_b ? cfg_i.max_inst : b;
        cmd_o.clamp_n  = 2'(c_a) + 2'(c_b);
      end
      idav_pkg::REQ_SAN_DISP: begin
        cmd_o.out_main = (a > cfg_i.max_axis) ? cfg_i.max_axis : a;
        cmd_o.out_iy   = (b > cfg_i.max_axis) ? cfg_i.max_axis : b;
        cmd_o.out_z    = (z > cfg_i.max_axis) ? cfg_i.max_axis : z;
        cmd_o.clamp_n  = 2'd1;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/idav_queue.sv -----
// ----------------------------------------------------------------------------
// idav_queue
// Two-entry queue of classified commands between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module idav_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          wr_i,
  input  wire idav_pkg::cmd_t wr_data_i,
  input  wire logic          rd_i,
  output idav_pkg::cmd_t     rd_data_o,
  output idav_pkg::q_stat_t  stat_o
);

  localparam int unsigned PtrW = $clog2(idav_pkg::Q_DEPTH);

  idav_pkg::cmd_t  mem_q [idav_pkg::Q_DEPTH];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [PtrW:0]   cnt_q, cnt_d;
  logic            do_wr, do_rd;

  assign stat_o.full  = (cnt_q == (PtrW+1)'(idav_pkg::Q_DEPTH));
  assign stat_o.valid = (cnt_q != '0);
  assign do_wr = wr_i && !stat_o.full;
  assign do_rd = rd_i && stat_o.valid;

  always_comb begin
    wptr_d = do_wr ? wptr_q + PtrW'(1) : wptr_q;
    rptr_d = do_rd ? rptr_q + PtrW'(1) : rptr_q;
    cnt_d  = cnt_q + (PtrW+1)'(do_wr) - (PtrW+1)'(do_rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

  assign rd_data_o = mem_q[rptr_q];

endmodule

`default_nettype wire

// ----- rtl/idav_back.sv -----
// ----------------------------------------------------------------------------
// idav_back
// Finishes the group product check of a dispatch, updates the statistics
// counters and the capped error count, and holds the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module idav_back #(
  parameter int unsigned COUNTER_WIDTH = 32
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire idav_pkg::cfg_t                   cfg_i,
  input  wire idav_pkg::q_stat_t                q_stat_i,
  input  wire idav_pkg::cmd_t                   q_data_i,
  output idav_pkg::bk_stat_t                    stat_o,
  output      logic                             m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output      logic [idav_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int unsigned CW = COUNTER_WIDTH;

  function automatic logic [31:0] lo32(input logic [CW-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[31:0];
  endfunction

  idav_pkg::bk_state_e state_q, state_d;
  idav_pkg::cmd_t      cmd_q, cmd_d;
  logic [63:0] plo_q, plo_d, phi_q, phi_d;
  logic        over_q, over_d;
  logic [64:0] psum;

  logic [CW-1:0] draws_q, draws_d, idxs_q, idxs_d, disps_q, disps_d;
  logic [CW-1:0] zero_q, zero_d, exc_q, exc_d, oob_q, oob_d, clamp_q, clamp_d;
  logic [15:0]   logged_q, logged_d;
  logic [16:0]   lsum;
  logic [2:0]    issue_tot;
  logic [1:0]    exc_tot;
  logic [idav_pkg::ISSUE_W-1:0] mask_tot;
  logic [31:0]   kind;
  logic          validate, out_free, commit;

  logic                             out_valid_q, out_valid_d;
  logic [idav_pkg::OUT_TDATA_W-1:0] out_data_q, out_data_d;

  assign out_free = !out_valid_q || m_axis_tready;

  // Sequencer: pop, two 32x32 partial products of (X*Y)*Z, check, commit.
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    plo_d       = plo_q;
    phi_d       = phi_q;
    over_d      = over_q;
    stat_o.pop    = 1'b0;
    stat_o.commit = 1'b0;
    psum = {1'b0, phi_q} + 65'(plo_q[63:32]);
    case (state_q)
      idav_pkg::BK_IDLE: begin
        if (q_stat_i.valid) begin
          stat_o.pop = 1'b1;
          cmd_d      = q_data_i;
          over_d     = 1'b0;
          state_d    = q_data_i.need_prod ? idav_pkg::BK_MUL_LO : idav_pkg::BK_COMMIT;
        end
      end
      idav_pkg::BK_MUL_LO: begin
        plo_d   = {32'b0, cmd_q.xy[31:0]} * {32'b0, cmd_q.out_z};
        state_d = idav_pkg::BK_MUL_HI;
      end
      idav_pkg::BK_MUL_HI: begin
        phi_d   = {32'b0, cmd_q.xy[63:32]} * {32'b0, cmd_q.out_z};
        state_d = idav_pkg::BK_CHECK;
      end
      idav_pkg::BK_CHECK: begin
        // The 96-bit product exceeds the 48-bit limit if any upper bit is set.
        over_d  = (|psum[64:16]) || ({psum[15:0], plo_q[31:0]} > cfg_i.max_total);
        state_d = idav_pkg::BK_COMMIT;
      end
      idav_pkg::BK_COMMIT: begin
        if (out_free) begin
          stat_o.commit = 1'b1;
          state_d       = idav_pkg::BK_IDLE;
        end
      end
      default: state_d = idav_pkg::BK_IDLE;
    endcase
  end

  assign commit = stat_o.commit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= idav_pkg::BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    plo_q  <= plo_d;
    phi_q  <= phi_d;
    over_q <= over_d;
  end

  // Statistics update for the committed command.
  always_comb begin
    draws_d  = draws_q;
    idxs_d   = idxs_q;
    disps_d  = disps_q;
    zero_d   = zero_q;
    exc_d    = exc_q;
    oob_d    = oob_q;
    clamp_d  = clamp_q;
    logged_d = logged_q;

    issue_tot = cmd_q.issue_n + 3'(over_q);
    exc_tot   = cmd_q.excess_n + 2'(over_q);
    lsum      = {1'b0, logged_q} + 17'(issue_tot);
    mask_tot  = cmd_q.mask;
    mask_tot[idav_pkg::ISS_EXC_GRP] = cmd_q.mask[idav_pkg::ISS_EXC_GRP] || over_q;
    validate  = (cmd_q.req == idav_pkg::REQ_CHK_DRAW) ||
                (cmd_q.req == idav_pkg::REQ_CHK_IDX) ||
                (cmd_q.req == idav_pkg::REQ_CHK_DISP);

    if (commit) begin
      case (cmd_q.req)
        idav_pkg::REQ_CLR_ERR: begin
          logged_d = '0;
        end
        idav_pkg::REQ_RST_STATS: begin
          draws_d  = '0;
          idxs_d   = '0;
          disps_d  = '0;
          zero_d   = '0;
          exc_d    = '0;
          oob_d    = '0;
          clamp_d  = '0;
          logged_d = '0;
        end
        default: begin
          if (cmd_q.req == idav_pkg::REQ_CHK_DRAW) draws_d = draws_q + CW'(1);
          if (cmd_q.req == idav_pkg::REQ_CHK_IDX)  idxs_d  = idxs_q + CW'(1);
          if (cmd_q.req == idav_pkg::REQ_CHK_DISP) disps_d = disps_q + CW'(1);
          zero_d  = zero_q + CW'(cmd_q.zero_n);
          exc_d   = exc_q + CW'(exc_tot);
          oob_d   = oob_q + CW'(cmd_q.bounds_n);
          clamp_d = clamp_q + CW'(cmd_q.clamp_n);
          // Each issue counts only while the log is below its cap.
          if (logged_q < cfg_i.max_log) begin
            logged_d = (lsum > {1'b0, cfg_i.max_log}) ? cfg_i.max_log : lsum[15:0];
          end
        end
      endcase
    end

    case (cmd_q.req)
      idav_pkg::REQ_CHK_DRAW, idav_pkg::REQ_SAN_DRAW: kind = lo32(draws_d);
      idav_pkg::REQ_CHK_IDX, idav_pkg::REQ_SAN_IDX:   kind = lo32(idxs_d);
      idav_pkg::REQ_CHK_DISP, idav_pkg::REQ_SAN_DISP: kind = lo32(disps_d);
      default:                                        kind = '0;
    endcase

    out_data_d  = {4'b0, lo32(clamp_d), lo32(oob_d), lo32(exc_d), lo32(zero_d), logged_d,
                   kind, cmd_q.out_z, cmd_q.out_iy, cmd_q.out_main,
                   validate ? mask_tot : {idav_pkg::ISSUE_W{1'b0}},
                   validate && (mask_tot == '0)};
    out_valid_d = commit ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      draws_q     <= '0;
      idxs_q      <= '0;
      disps_q     <= '0;
      zero_q      <= '0;
      exc_q       <= '0;
      oob_q       <= '0;
      clamp_q     <= '0;
      logged_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      draws_q     <= draws_d;
      idxs_q      <= idxs_d;
      disps_q     <= disps_d;
      zero_q      <= zero_d;
      exc_q       <= exc_d;
      oob_q       <= oob_d;
      clamp_q     <= clamp_d;
      logged_q    <= logged_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

// ----- rtl/indirect_draw_args_validator.sv -----
// ----------------------------------------------------------------------------
// indirect_draw_args_validator
// Checks or clamps the arguments of indirect draw and dispatch commands and
// keeps running statistics on the issues found.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                     Payload
//  s_axis    in         s_axis_tvalid / tready        tuser req, tdata arguments
//  m_axis    out        m_axis_tvalid / tready        tdata result word
//  cfg       in         cfg_we_i (no wait)            cfg_idx_i, cfg_data_i
//
//  A command passes the back end through pop and commit; a validated
//  dispatch adds two partial products and a check, as the 96-bit group
//  product X*Y*Z is formed by one 32x32 multiplier in the front and two
//  32x32 partial products in the back. The front accepts into a two-entry
//  queue while the back works, and the result register frees as the word
//  is taken. Reset is asynchronous, active low, and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module indirect_draw_args_validator #(
  parameter int unsigned COUNTER_WIDTH = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output      logic                              s_axis_tready,
  // count_main, instance_or_y, group_z, first_element, vertex_offset, buffer_size
  input  wire logic [idav_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // req_type
  input  wire logic [idav_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
  output      logic                              m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // valid_res, issue_mask, out_main, out_instance_or_y, out_group_z, kind_total,
  // errors_logged, zero_warnings, excess_errors, bounds_errors, clamp_total, pad
  output      logic [idav_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input  wire logic                              cfg_we_i,
  input  wire logic [idav_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [idav_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  idav_pkg::cfg_t     cfg;
  idav_pkg::cmd_t     fr_cmd, q_head;
  idav_pkg::q_stat_t  q_stat;
  idav_pkg::bk_stat_t bk_stat;
  logic               fr_wr;

  idav_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  idav_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cfg_i         (cfg),
    .q_stat_i      (q_stat),
    .q_wr_o        (fr_wr),
    .cmd_o         (fr_cmd)
  );

  idav_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (fr_wr),
    .wr_data_i (fr_cmd),
    .rd_i      (bk_stat.pop),
    .rd_data_o (q_head),
    .stat_o    (q_stat)
  );

  idav_back #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .q_stat_i      (q_stat),
    .q_data_i      (q_head),
    .stat_o        (bk_stat),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // The back end only pops a queue entry that is there.
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_stat.pop |-> q_stat.valid)
    else $error("back end popped an empty queue");

  // A commit always leaves a result word on the output.
  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_stat.commit |=> m_axis_tvalid)
    else $error("committed result not presented");

  // A passing validation carries no issue bits.
  a_valid_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[11:1] == '0))
    else $error("valid result with issue bits set");

endmodule

`default_nettype wire

// ----- sim/indirect_draw_args_validator_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// indirect_draw_args_validator_tb
// Drives validate, sanitize and housekeeping commands through the validator
// under several limit settings, predicts each result word in a scoreboard
// and compares it field by field. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------

module indirect_draw_args_validator_tb;
  import idav_pkg::*;

  localparam int unsigned IDLE_LIMIT = 2000;

  typedef struct packed {
    req_e        req;
    logic [31:0] count_main;
    logic [31:0] inst_y;
    logic [31:0] grp_z;
    logic [31:0] first_elem;
    logic [31:0] vtx_ofs;
    logic [31:0] buf_size;
  } args_t;

  typedef struct packed {
    logic               ok;
    logic [ISSUE_W-1:0] issues;
    logic [31:0]        o_main;
    logic [31:0]        o_iy;
    logic [31:0]        o_z;
    logic [31:0]        kind;
    logic [15:0]        logged;
    logic [31:0]        zero_n;
    logic [31:0]        excess_n;
    logic [31:0]        bounds_n;
    logic [31:0]        clamp_n;
  } verdict_t;

  class validator_scoreboard;
    logic [31:0] lim_vtx, lim_idx, lim_inst, lim_axis;
    logic [47:0] lim_total;
    logic        warn_zero;
    logic [15:0] log_cap;
    logic [31:0] draws_cnt, indexed_cnt, disp_cnt;
    logic [31:0] zero_cnt, excess_cnt, bounds_cnt, clamp_cnt;
    logic [15:0] logged;
    verdict_t    expected_verdicts[$];
    int unsigned errors;
    int unsigned checked;

    function new();
      lim_vtx = RST_MAX_VTX;
      lim_idx = RST_MAX_IDX;
      lim_inst = RST_MAX_INST;
      lim_axis = RST_MAX_AXIS;
      lim_total = RST_MAX_TOTAL;
      warn_zero = 1'b1;
      log_cap = RST_MAX_LOG;
      clear_stats();
      errors = 0;
      checked = 0;
    endfunction

    function void clear_stats();
      draws_cnt = '0;
      indexed_cnt = '0;
      disp_cnt = '0;
      zero_cnt = '0;
      excess_cnt = '0;
      bounds_cnt = '0;
      clamp_cnt = '0;
      logged = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_MAX_VTX:   lim_vtx = data[31:0];
        CFG_MAX_IDX:   lim_idx = data[31:0];
        CFG_MAX_INST:  lim_inst = data[31:0];
        CFG_MAX_AXIS:  lim_axis = data[31:0];
        CFG_MAX_TOTAL: lim_total = data[47:0];
        CFG_WARN_ZERO: warn_zero = data[0];
        CFG_MAX_LOG:   log_cap = data[15:0];
        default: ;
      endcase
    endfunction

    function void log_issue();
      if (logged < log_cap) logged++;
    endfunction

    function logic [31:0] clamp_arg(logic [31:0] v, logic [31:0] lim, bit counted);
      if (v > lim) begin
        if (counted) clamp_cnt++;
        return lim;
      end
      return v;
    endfunction

    function int unsigned pending();
      return expected_verdicts.size();
    endfunction

    // Works out the result word of one accepted command and queues it.
    function void note_command(args_t c);
      verdict_t    v;
      bit          idx;
      logic [31:0] lim;
      logic [32:0] reach;
      logic [63:0] xy;
      logic [95:0] prod;
      v = '0;
      v.o_main = c.count_main;
      v.o_iy = c.inst_y;
      v.o_z = c.grp_z;
      idx = (c.req == REQ_CHK_IDX) || (c.req == REQ_SAN_IDX);
      case (c.req)
        REQ_CHK_DRAW, REQ_CHK_IDX: begin
          lim = idx ? lim_idx : lim_vtx;
          if (idx) indexed_cnt++; else draws_cnt++;
          if (c.count_main == 0 && warn_zero) begin
            v.issues[idx ? ISS_ZERO_IDX : ISS_ZERO_VTX] = 1'b1;
            log_issue();
            zero_cnt++;
          end
          if (c.inst_y == 0 && warn_zero) begin
            v.issues[ISS_ZERO_INST] = 1'b1;
            log_issue();
            zero_cnt++;
          end
          if (c.count_main > lim) begin
            v.issues[idx ? ISS_EXC_IDX : ISS_EXC_VTX] = 1'b1;
            log_issue();
            excess_cnt++;
          end
          if (c.inst_y > lim_inst) begin
            v.issues[ISS_EXC_INST] = 1'b1;
            log_issue();
            excess_cnt++;
          end
          // The end of the range is formed without wrapping.
          reach = {1'b0, c.first_elem} + {1'b0, c.count_main};
          if (c.buf_size != ALL_ONES32 && reach > {1'b0, c.buf_size}) begin
            v.issues[idx ? ISS_OOB_IDX : ISS_OOB_VTX] = 1'b1;
            log_issue();
            bounds_cnt++;
          end
          // A negative offset is logged but counts in no statistic.
          if (idx && c.vtx_ofs[31]) begin
            v.issues[ISS_NEG_OFS] = 1'b1;
            log_issue();
          end
          v.kind = idx ? indexed_cnt : draws_cnt;
        end
        REQ_CHK_DISP: begin
          disp_cnt++;
          if ((c.count_main == 0 || c.inst_y == 0 || c.grp_z == 0) && warn_zero) begin
            v.issues[ISS_ZERO_GRP] = 1'b1;
            log_issue();
            zero_cnt++;
          end
          if (c.count_main > lim_axis || c.inst_y > lim_axis || c.grp_z > lim_axis) begin
            v.issues[ISS_EXC_GRP] = 1'b1;
            log_issue();
            excess_cnt++;
          end
          // The total check is a second issue of its own, on the same mask bit.
          xy = c.count_main * c.inst_y;
          prod = {32'b0, xy} * {64'b0, c.grp_z};
          if (prod > {48'b0, lim_total}) begin
            v.issues[ISS_EXC_GRP] = 1'b1;
            log_issue();
            excess_cnt++;
          end
          v.kind = disp_cnt;
        end
        REQ_SAN_DRAW, REQ_SAN_IDX: begin
          v.o_main = clamp_arg(c.count_main, idx ? lim_idx : lim_vtx, 1'b1);
          v.o_iy = clamp_arg(c.inst_y, lim_inst, 1'b1);
          v.kind = idx ? indexed_cnt : draws_cnt;
        end
        REQ_SAN_DISP: begin
          v.o_main = clamp_arg(c.count_main, lim_axis, 1'b0);
          v.o_iy = clamp_arg(c.inst_y, lim_axis, 1'b0);
          v.o_z = clamp_arg(c.grp_z, lim_axis, 1'b0);
          clamp_cnt++;
          v.kind = disp_cnt;
        end
        REQ_CLR_ERR: logged = '0;
        default: clear_stats();
      endcase
      v.ok = (c.req == REQ_CHK_DRAW || c.req == REQ_CHK_IDX || c.req == REQ_CHK_DISP) &&
             (v.issues == '0);
      v.logged = logged;
      v.zero_n = zero_cnt;
      v.excess_n = excess_cnt;
      v.bounds_n = bounds_cnt;
      v.clamp_n = clamp_cnt;
      expected_verdicts = {expected_verdicts, v};
    endfunction

    function void match_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_word(logic [OUT_TDATA_W-1:0] w);
      verdict_t v;
      if (expected_verdicts.size() == 0) begin
        errors++;
        $display("%0t: result word with nothing expected, actual %0h", $time, w);
        return;
      end
      v = expected_verdicts.pop_front();
      checked++;
      match_field("valid_res", 32'(v.ok), 32'(w[0]));
      match_field("issue_mask", 32'(v.issues), 32'(w[11:1]));
      match_field("out_main", v.o_main, w[43:12]);
      match_field("out_instance_or_y", v.o_iy, w[75:44]);
      match_field("out_group_z", v.o_z, w[107:76]);
      match_field("kind_total", v.kind, w[139:108]);
      match_field("errors_logged", 32'(v.logged), 32'(w[155:140]));
      match_field("zero_warnings", v.zero_n, w[187:156]);
      match_field("excess_errors", v.excess_n, w[219:188]);
      match_field("bounds_errors", v.bounds_n, w[251:220]);
      match_field("clamp_total", v.clamp_n, w[283:252]);
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // count_main, instance_or_y, group_z, first_element, vertex_offset, buffer_size
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  // req_type
  logic [IN_TUSER_W-1:0]  s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // valid_res, issue_mask, out_main, out_instance_or_y, out_group_z, kind_total,
  // errors_logged, zero_warnings, excess_errors, bounds_errors, clamp_total, pad
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;

  validator_scoreboard sb;
  bit                  tx_idle_en;
  bit                  rx_stall_en;
  int unsigned         idle_cycles;
  int unsigned         kind_seen[8];
  int unsigned         settings_used;

  indirect_draw_args_validator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Result side: ready drops in random bursts while stalls are enabled.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_stall_en && $urandom_range(0, 7) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(1, 19) - 1) @(negedge clk_i);
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata);
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(args_t c);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = c.req;
    s_axis_tdata = {c.buf_size, c.vtx_ofs, c.first_elem, c.grp_z, c.inst_y, c.count_main};
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    sb.note_command(c);
    kind_seen[c.req]++;
    @(negedge clk_i);
  endtask

  task automatic send_cmd(req_e r, logic [31:0] a, logic [31:0] b, logic [31:0] z,
                          logic [31:0] first, logic [31:0] voff, logic [31:0] size);
    args_t c;
    c = '{req: r, count_main: a, inst_y: b, grp_z: z, first_elem: first,
          vtx_ofs: voff, buf_size: size};
    send_word(c);
  endtask

  // Holds the sender off until every result is back and the pipeline is empty.
  task automatic drain_results();
    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic apply_limits(logic [31:0] vtx, logic [31:0] ind, logic [31:0] inst,
                              logic [31:0] axis, logic [47:0] total, logic warn,
                              logic [15:0] cap);
    cfg_write(CFG_MAX_VTX, 48'(vtx));
    cfg_write(CFG_MAX_IDX, 48'(ind));
    cfg_write(CFG_MAX_INST, 48'(inst));
    cfg_write(CFG_MAX_AXIS, 48'(axis));
    cfg_write(CFG_MAX_TOTAL, total);
    cfg_write(CFG_WARN_ZERO, 48'(warn));
    cfg_write(CFG_MAX_LOG, 48'(cap));
    settings_used++;
  endtask

  function automatic logic [31:0] near_limit(logic [31:0] lim);
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return lim;
      2: return lim + 32'd1;
      3: return lim - 32'd1;
      4: return $urandom;
      5: return $urandom_range(1, 64);
      6: return ALL_ONES32;
      default: return lim - $urandom_range(0, 3);
    endcase
  endfunction

  // Mostly well-formed commands with counts close to the current limits.
  function automatic args_t random_command();
    args_t       c;
    int unsigned r;
    logic [63:0] ab;
    logic [63:0] quot;
    r = $urandom_range(0, 99);
    if (r < 22) c.req = REQ_CHK_DRAW;
    else if (r < 44) c.req = REQ_CHK_IDX;
    else if (r < 62) c.req = REQ_CHK_DISP;
    else if (r < 72) c.req = REQ_SAN_DRAW;
    else if (r < 82) c.req = REQ_SAN_IDX;
    else if (r < 92) c.req = REQ_SAN_DISP;
    else if (r < 96) c.req = REQ_CLR_ERR;
    else c.req = REQ_RST_STATS;
    c.first_elem = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 4096);
    c.vtx_ofs = $urandom;
    c.grp_z = $urandom;
    if (c.req == REQ_CHK_DISP || c.req == REQ_SAN_DISP) begin
      if ($urandom_range(0, 1)) begin
        c.count_main = near_limit(sb.lim_axis);
        c.inst_y = near_limit(sb.lim_axis);
        c.grp_z = near_limit(sb.lim_axis);
      end else begin
        // Aim Z so that the group product lands right at the total limit.
        c.count_main = $urandom_range(1, 64);
        c.inst_y = $urandom_range(1, 64);
        ab = c.count_main * c.inst_y;
        quot = {16'b0, sb.lim_total} / ab;
        c.grp_z = quot[31:0] + $urandom_range(0, 2) - 1;
      end
    end else begin
      c.count_main = (c.req == REQ_CHK_IDX || c.req == REQ_SAN_IDX) ?
                     near_limit(sb.lim_idx) : near_limit(sb.lim_vtx);
      c.inst_y = near_limit(sb.lim_inst);
    end
    case ($urandom_range(0, 4))
      0: c.buf_size = ALL_ONES32;
      1: c.buf_size = $urandom;
      default: c.buf_size = c.first_elem + c.count_main + $urandom_range(0, 2) - 1;
    endcase
    return c;
  endfunction

  task automatic run_random(int unsigned n);
    repeat (n) send_word(random_command());
  endtask

  initial begin
    sb = new();
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    tx_idle_en = 1'b1;
    rx_stall_en = 1'b1;
    settings_used = 1;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed commands against the reset limits.
    send_cmd(REQ_CHK_DRAW, 32'd3, 32'd1, 32'd7, 32'd0, 32'd0, 32'd10);
    send_cmd(REQ_CHK_DRAW, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, ALL_ONES32);
    send_cmd(REQ_CHK_DRAW, ALL_ONES32, ALL_ONES32, ALL_ONES32, ALL_ONES32, ALL_ONES32, 32'd5);
    send_cmd(REQ_CHK_DRAW, 32'd16777216, 32'd65536, 32'd0, 32'd0, 32'd0, 32'd16777216);
    send_cmd(REQ_CHK_DRAW, 32'd16777217, 32'd65537, 32'd1, 32'd1, 32'd0, 32'd16777217);
    send_cmd(REQ_CHK_IDX, 32'd0, 32'd1, 32'd0, 32'd0, 32'h8000_0000, 32'd100);
    send_cmd(REQ_CHK_IDX, 32'd10, 32'd2, 32'd0, 32'd5, 32'h7FFF_FFFF, 32'd15);
    send_cmd(REQ_CHK_IDX, 32'd10, 32'd2, 32'd0, 32'd6, 32'hFFFF_FFFF, 32'd15);
    send_cmd(REQ_CHK_IDX, 32'd16777217, 32'd0, 32'd0, 32'd0, 32'd0, ALL_ONES32);
    send_cmd(REQ_CHK_DISP, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    send_cmd(REQ_CHK_DISP, 32'd65536, 32'd1, 32'd1, 32'd0, 32'd0, 32'd0);
    send_cmd(REQ_CHK_DISP, 32'd2048, 32'd2048, 32'd1, 32'd0, 32'd0, 32'd0);
    send_cmd(REQ_CHK_DISP, 32'd2048, 32'd2048, 32'd2, 32'd0, 32'd0, 32'd0);
    send_cmd(REQ_CHK_DISP, 32'd65536, 32'd65535, 32'd2, 32'd0, 32'd0, 32'd0);
    send_cmd(REQ_CHK_DISP, ALL_ONES32, ALL_ONES32, ALL_ONES32, 32'd0, 32'd0, 32'd0);
    send_cmd(REQ_CHK_DISP, 32'd0, ALL_ONES32, 32'd1, 32'd0, 32'd0, 32'd0);
    send_cmd(REQ_SAN_DRAW, 32'd16777217, 32'd65537, 32'd9, 32'd0, 32'd0, 32'd0);
    send_cmd(REQ_SAN_DRAW, 32'd5, 32'd5, 32'd9, 32'd0, 32'd0, 32'd0);
    send_cmd(REQ_SAN_IDX, ALL_ONES32, 32'd0, 32'd9, 32'd0, 32'd0, 32'd0);
    send_cmd(REQ_SAN_DISP, 32'd70000, 32'd1, ALL_ONES32, 32'd0, 32'd0, 32'd0);
    send_cmd(REQ_SAN_DISP, 32'd1, 32'd1, 32'd1, 32'd0, 32'd0, 32'd0);
    send_cmd(REQ_CLR_ERR, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h1234_5678, 32'd0, 32'd0, 32'd0);
    send_cmd(REQ_CHK_DRAW, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    send_cmd(REQ_RST_STATS, 32'hDEAD_0001, 32'hFFFF_0000, 32'h0000_FFFF, 32'd0, 32'd0, 32'd0);
    send_cmd(REQ_CHK_IDX, 32'd1, 32'd1, 32'd0, 32'd0, 32'd0, ALL_ONES32);
    // The sender waits here until every result has come back.
    drain_results();
    run_random(150);

    // Tight limits and a small log cap.
    drain_results();
    apply_limits(32'd100, 32'd200, 32'd4, 32'd8, 48'd100, 1'b1, 16'd5);
    run_random(200);

    // Every limit at zero, zero warnings off, nothing logged.
    drain_results();
    apply_limits(32'd0, 32'd0, 32'd0, 32'd0, 48'd0, 1'b0, 16'd0);
    run_random(150);

    // Every limit at its largest value.
    drain_results();
    apply_limits(ALL_ONES32, ALL_ONES32, ALL_ONES32, ALL_ONES32, 48'hFFFF_FFFF_FFFF,
                 1'b1, 16'hFFFF);
    run_random(150);

    drain_results();
    apply_limits($urandom, $urandom, $urandom_range(0, 1 << 20), $urandom_range(0, 1 << 16),
                 {16'($urandom), 32'($urandom)}, 1'($urandom), 16'($urandom_range(0, 300)));
    run_random(200);

    // Back to the reset limits, with both sides streaming at full rate.
    drain_results();
    apply_limits(RST_MAX_VTX, RST_MAX_IDX, RST_MAX_INST, RST_MAX_AXIS, RST_MAX_TOTAL,
                 1'b1, RST_MAX_LOG);
    tx_idle_en = 1'b0;
    rx_stall_en = 1'b0;
    run_random(150);

    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);

    $display("Covered %0d validate, %0d sanitize and %0d housekeeping commands, %0d limit sets.",
             kind_seen[REQ_CHK_DRAW] + kind_seen[REQ_CHK_IDX] + kind_seen[REQ_CHK_DISP],
             kind_seen[REQ_SAN_DRAW] + kind_seen[REQ_SAN_IDX] + kind_seen[REQ_SAN_DISP],
             kind_seen[REQ_CLR_ERR] + kind_seen[REQ_RST_STATS], settings_used);
    $display("Checked %0d result words, %0d field mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
